// ===== rtl/sstf_pkg.sv =====
// Shared types and constants for the shortest-seek-time-first scheduler.
package sstf_pkg;

  localparam int TRACK_W  = 16;
  localparam int ARR_W    = 6;
  localparam int STATUS_W = 2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd3;

  typedef struct packed {
    logic               operation;
    logic [TRACK_W-1:0] track;
  } item_t;

  typedef struct packed {
    logic [TRACK_W-1:0]  served_track;
    logic [ARR_W-1:0]    arrival_index;
    logic                last;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic                load;
    logic                run;
    logic                scan_init;
    logic                find;
    logic                seek;
    logic                emit;
    logic                emit_err;
    logic [STATUS_W-1:0] err_status;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_done;
    logic found;
    logic more;
  } dp_sts_t;

endpackage

// ===== rtl/sstf_disk_scheduler.sv =====
// Top level of the shortest-seek-time-first disk request scheduler.
// A load transaction stores one track request, or marks the run as dropped when the
// store is full; busy stays low. A run holds busy high through a start search pass and
// then, for each result, a seek pass and an emit state: every result needs one full
// pass over the request memory through its single read port. Results come out on
// result_valid for one cycle each and cannot be stalled; an empty store or an
// absent start track gives one error result after the run is taken.
module sstf_disk_scheduler #(
  parameter int MAX_REQUESTS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sstf_pkg::item_t   item,
  output logic              result_valid,
  output sstf_pkg::result_t result
);
  import sstf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sstf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (item.operation),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  sstf_datapath #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .track        (item.track),
    .sts          (sts),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== rtl/sstf_datapath.sv =====
// Datapath: request memory, scan unit, span keys and result register.
module sstf_datapath #(
  parameter int MAX_REQUESTS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  sstf_pkg::dp_cmd_t cmd,
  input  logic [sstf_pkg::TRACK_W-1:0] track,
  output sstf_pkg::dp_sts_t sts,
  output logic             result_valid,
  output sstf_pkg::result_t result
);
  import sstf_pkg::*;

  localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CW = $clog2(MAX_REQUESTS + 1);
  localparam int KW = TRACK_W + AW;

  logic [TRACK_W-1:0]  mem [MAX_REQUESTS];
  logic [TRACK_W-1:0]  rdata;
  logic [CW-1:0]       count;
  logic                dropped;
  logic [CW-1:0]       n;
  logic [STATUS_W-1:0] ok_status;
  logic [TRACK_W-1:0]  start_trk;
  logic [CW-1:0]       sc;
  logic                rd_v;
  logic [AW-1:0]       rd_idx;
  logic                found;
  logic                bf;
  logic                af;
  logic [KW-1:0]       b_key;
  logic [KW-1:0]       a_key;
  logic [KW-1:0]       lo_key;
  logic [KW-1:0]       hi_key;
  logic [KW-1:0]       cur_key;
  logic [KW-1:0]       k;
  logic                full;
  logic                scanning;
  logic [TRACK_W-1:0]  cur_trk;
  logic [TRACK_W-1:0]  dlo;
  logic [TRACK_W-1:0]  dhi;
  logic                take_low;

  assign full     = (count == CW'(MAX_REQUESTS));
  assign scanning = cmd.find | cmd.seek;
  assign k        = {rdata, rd_idx};
  assign cur_trk  = cur_key[KW-1:AW];
  assign dlo      = cur_trk - b_key[KW-1:AW];
  assign dhi      = a_key[KW-1:AW] - cur_trk;
  assign take_low = !af || (bf && (dlo < dhi));

  assign sts.count_zero = (count == '0);
  assign sts.scan_done  = (sc == n) && !rd_v;
  assign sts.found      = found;
  assign sts.more       = bf | af;

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[count[AW-1:0]] <= track;
    end
    rdata <= mem[sc[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        count <= count + 1'b1;
      end
    end else if (cmd.run) begin
      count   <= '0;
      dropped <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run) begin
      n         <= count;
      ok_status <= dropped ? ST_DROPPED : ST_OK;
      start_trk <= track;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc    <= '0;
      rd_v  <= 1'b0;
      found <= 1'b0;
      bf    <= 1'b0;
      af    <= 1'b0;
    end else if (cmd.scan_init) begin
      sc   <= '0;
      rd_v <= 1'b0;
      bf   <= 1'b0;
      af   <= 1'b0;
      if (cmd.run) begin
        found <= 1'b0;
      end
    end else if (scanning) begin
      if (sc != n) begin
        sc     <= sc + 1'b1;
        rd_v   <= 1'b1;
        rd_idx <= sc[AW-1:0];
      end else begin
        rd_v <= 1'b0;
      end
      if (rd_v && cmd.find && !found && (rdata == start_trk)) begin
        found <= 1'b1;
      end
      if (rd_v && cmd.seek) begin
        if ((k < lo_key) && (!bf || (k > b_key))) begin
          bf <= 1'b1;
        end
        if ((k > hi_key) && (!af || (k < a_key))) begin
          af <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scanning && rd_v) begin
      if (cmd.find && !found && (rdata == start_trk)) begin
        cur_key <= k;
        lo_key  <= k;
        hi_key  <= k;
      end
      if (cmd.seek) begin
        if ((k < lo_key) && (!bf || (k > b_key))) begin
          b_key <= k;
        end
        if ((k > hi_key) && (!af || (k < a_key))) begin
          a_key <= k;
        end
      end
    end else if (cmd.emit && (bf || af)) begin
      if (take_low) begin
        lo_key  <= b_key;
        cur_key <= b_key;
      end else begin
        hi_key  <= a_key;
        cur_key <= a_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit | cmd.emit_err;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.served_track  <= cur_trk;
      result.arrival_index <= ARR_W'(cur_key[AW-1:0]);
      result.last          <= !(bf | af);
      result.status        <= ok_status;
    end else if (cmd.emit_err) begin
      result.served_track  <= '0;
      result.arrival_index <= '0;
      result.last          <= 1'b1;
      result.status        <= cmd.err_status;
    end
  end

endmodule

// ===== rtl/sstf_ctrl.sv =====
// Controller state machine sequencing loads, start search, seek passes and emission.
module sstf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              operation,
  input  sstf_pkg::dp_sts_t sts,
  output sstf_pkg::dp_cmd_t cmd,
  output logic              busy
);
  import sstf_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIND   = 3'd1;
  localparam logic [2:0] S_SEEK   = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_EMPTY  = 3'd4;
  localparam logic [2:0] S_ABSENT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (operation == OP_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.run       = 1'b1;
            cmd.scan_init = 1'b1;
            state_next    = sts.count_zero ? S_EMPTY : S_FIND;
          end
        end
      end
      S_FIND: begin
        cmd.find = 1'b1;
        if (sts.scan_done) begin
          if (sts.found) begin
            cmd.scan_init = 1'b1;
            state_next    = S_SEEK;
          end else begin
            state_next = S_ABSENT;
          end
        end
      end
      S_SEEK: begin
        cmd.seek = 1'b1;
        if (sts.scan_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.more) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SEEK;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMPTY: begin
        cmd.emit_err   = 1'b1;
        cmd.err_status = ST_EMPTY;
        state_next     = S_IDLE;
      end
      S_ABSENT: begin
        cmd.emit_err   = 1'b1;
        cmd.err_status = ST_ABSENT;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  a_find_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND) |=> (state == S_FIND || state == S_SEEK || state == S_ABSENT))
    else $error("start search left to an unexpected state");
  a_seek_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEEK && sts.scan_done) |=> (state == S_EMIT))
    else $error("finished seek pass did not emit");
  a_emit_final: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !sts.more) |=> (state == S_IDLE))
    else $error("run did not end after its final result");
`endif

endmodule

// ===== sim/tb_sstf_disk_scheduler.sv =====
// Self-checking testbench for the shortest-seek-time-first disk request scheduler.
`timescale 1ns / 1ps

class sstf_service_board;
  localparam int DEPTH = 64;

  logic [15:0]       requests[$];
  bit                loads_dropped;
  sstf_pkg::result_t expected_visits[$];
  int                errors;
  int                runs;
  int                empty_runs;
  int                absent_runs;
  int                dropped_runs;
  int                visits_checked;

  function int pending();
    return expected_visits.size();
  endfunction

  function void add_visit(logic [15:0] trk, logic [5:0] arr, logic fin, logic [1:0] st);
    sstf_pkg::result_t r;
    r.served_track  = trk;
    r.arrival_index = arr;
    r.last          = fin;
    r.status        = st;
    expected_visits.push_back(r);
  endfunction

  function void plan_service(logic [15:0] head);
    logic [15:0] trk[DEPTH];
    logic [5:0]  arr[DEPTH];
    logic [15:0] t;
    logic [5:0]  a;
    logic [1:0]  ok_st;
    int          n, i, j, pos, lo, hi, nxt, cur;
    bit          found;
    n = requests.size();
    ok_st = loads_dropped ? sstf_pkg::ST_DROPPED : sstf_pkg::ST_OK;
    runs++;
    if (loads_dropped) dropped_runs++;
    loads_dropped = 0;
    for (i = 0; i < n; i++) begin
      trk[i] = requests[i];
      arr[i] = i[5:0];
    end
    requests.delete();
    if (n == 0) begin
      empty_runs++;
      add_visit('0, '0, 1'b1, sstf_pkg::ST_EMPTY);
      return;
    end
    // stable sort by track, arrival order kept among equal tracks
    for (i = 1; i < n; i++) begin
      t = trk[i];
      a = arr[i];
      j = i;
      while (j > 0 && trk[j-1] > t) begin
        trk[j] = trk[j-1];
        arr[j] = arr[j-1];
        j--;
      end
      trk[j] = t;
      arr[j] = a;
    end
    found = 0;
    pos = 0;
    for (i = 0; i < n && !found; i++) begin
      if (trk[i] == head) begin
        pos = i;
        found = 1;
      end
    end
    if (!found) begin
      absent_runs++;
      add_visit('0, '0, 1'b1, sstf_pkg::ST_ABSENT);
      return;
    end
    cur = pos;
    lo = pos;
    hi = pos + 1;
    add_visit(trk[pos], arr[pos], n == 1, ok_st);
    while (lo > 0 || hi < n) begin
      if (hi >= n) begin
        lo--;
        nxt = lo;
      end else if (lo == 0) begin
        nxt = hi;
        hi++;
      end else if (int'(trk[cur]) - int'(trk[lo-1]) < int'(trk[hi]) - int'(trk[cur])) begin
        lo--;
        nxt = lo;
      end else begin
        nxt = hi;
        hi++;
      end
      cur = nxt;
      add_visit(trk[nxt], arr[nxt], lo == 0 && hi >= n, ok_st);
    end
  endfunction

  function void note_transaction(sstf_pkg::item_t it);
    if (it.operation == sstf_pkg::OP_LOAD) begin
      if (requests.size() < DEPTH) requests.push_back(it.track);
      else loads_dropped = 1;
    end else begin
      plan_service(it.track);
    end
  endfunction

  function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
    if (seen !== want) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
    end
  endfunction

  function void check_visit(sstf_pkg::result_t got);
    sstf_pkg::result_t want;
    if (expected_visits.size() == 0) begin
      errors++;
      $display("%0t: result with none expected, actual track %0d arrival %0d last %0d status %0d",
               $time, got.served_track, got.arrival_index, got.last, got.status);
      return;
    end
    want = expected_visits.pop_front();
    visits_checked++;
    compare_field("served_track", want.served_track, got.served_track);
    compare_field("arrival_index", 16'(want.arrival_index), 16'(got.arrival_index));
    compare_field("last", 16'(want.last), 16'(got.last));
    compare_field("status", 16'(want.status), 16'(got.status));
  endfunction
endclass

module tb_sstf_disk_scheduler;
  import sstf_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 290;
  localparam int TAIL_CYCLES  = 200;

  logic    clk;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    result_valid;
  result_t result;

  sstf_service_board board;
  int                burst_left = 0;
  int                cycle_count;

  sstf_disk_scheduler dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (!rst && board != null) begin
      if (result_valid) board.check_visit(result);
      if (start && !busy) board.note_transaction(item);
    end
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("sstf_disk_scheduler verification failed");
    $finish;
  end

  task automatic send_item(logic op, logic [15:0] trk);
    item <= {op, trk};
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Hold start low between bursts of random length.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
  endtask

  function automatic logic [15:0] pick_track(int mode, logic [15:0] base);
    case (mode)
      0: return 16'($urandom_range(0, 65535));
      1: return base + 16'($urandom_range(0, 15));
      2: begin
        case ($urandom_range(0, 4))
          0: return 16'd0;
          1: return 16'd65535;
          2: return 16'd1;
          3: return 16'd65534;
          default: return 16'd32768;
        endcase
      end
      default: return 16'($urandom_range(0, 7));
    endcase
  endfunction

  initial begin : stimulus
    logic [15:0] loaded[$];
    logic [15:0] t, base, head;
    int          items, seq, n, mode, i, r;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty store, extremes with duplicates, absent start, tie, top start, single request
    send_item(OP_RUN, 16'd5);
    send_item(OP_LOAD, 16'd0);
    send_item(OP_LOAD, 16'd65535);
    send_item(OP_LOAD, 16'd0);
    send_item(OP_RUN, 16'd0);
    send_item(OP_LOAD, 16'd100);
    send_item(OP_LOAD, 16'd200);
    send_item(OP_RUN, 16'd150);
    send_item(OP_LOAD, 16'd10);
    send_item(OP_LOAD, 16'd20);
    send_item(OP_LOAD, 16'd30);
    send_item(OP_LOAD, 16'd30);
    send_item(OP_RUN, 16'd20);
    send_item(OP_LOAD, 16'd5);
    send_item(OP_LOAD, 16'd65535);
    send_item(OP_RUN, 16'd65535);
    send_item(OP_LOAD, 16'd7);
    send_item(OP_RUN, 16'd7);

    items = 0;
    seq = 0;
    while (items < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 3);
      r = $urandom_range(0, 19);
      if (seq == 0) begin
        n = 66;
        mode = 0;
      end else if (seq == 1) begin
        n = 65;
        mode = 3;
      end else if (r == 0) n = 0;
      else if (r == 1) n = $urandom_range(60, 66);
      else if (r < 4) n = $urandom_range(9, 24);
      else n = $urandom_range(1, 8);
      base = 16'($urandom_range(0, 65535));
      loaded.delete();
      for (i = 0; i < n; i++) begin
        t = pick_track(mode, base);
        loaded.push_back(t);
        pace();
        send_item(OP_LOAD, t);
        items++;
      end
      r = $urandom_range(0, 9);
      if (seq == 1) head = 16'd1000;
      else if (loaded.size() == 0 || r == 8) head = 16'($urandom_range(0, 65535));
      else if (r == 9) head = loaded[$urandom_range(0, loaded.size() - 1)] + 16'd1;
      else head = loaded[$urandom_range(0, loaded.size() - 1)];
      pace();
      send_item(OP_RUN, head);
      items++;
      if (seq == 5) begin
        start <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
      end
      seq++;
    end

    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (board.pending() != 0) begin
      board.errors++;
      $display("%0t: results expected %0d more actual 0", $time, board.pending());
    end
    $display("Ran %0d schedules: %0d empty, %0d with absent start, %0d after dropped loads.",
             board.runs, board.empty_runs, board.absent_runs, board.dropped_runs);
    $display("Checked %0d service-order results, %0d mismatches.",
             board.visits_checked, board.errors);
    if (board.errors == 0) begin
      $display("sstf_disk_scheduler verification clean");
    end else begin
      $display("sstf_disk_scheduler verification failed");
    end
    $finish;
  end
endmodule
